[rtl/pmb_pkg.sv]
`timescale 1ns / 1ps

package pmb_pkg;

  // Field widths of the request and response.
  localparam int FUNC_W     = 2;
  localparam int FRAME_W    = 12;
  localparam int CHAN_W     = 3;
  localparam int LEVEL_W    = 32;
  localparam int WORD_W     = 32;

  // Configuration register widths and port shape.
  localparam int FMT_W      = 2;
  localparam int CHCNT_W    = 4;
  localparam int FRCNT_W    = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  // Datapath widths: the product of a level magnitude (up to 2^31) with an
  // amplitude below 2^31 stays below 2^62, the rounded scale below 2^32,
  // and a decoded sample plus or minus the scale fits in 35 signed bits.
  localparam int PROD_W     = 62;
  localparam int RND_W      = 32;
  localparam int DEC_W      = 33;
  localparam int SUM_W      = 35;
  localparam int Q_FRAC     = 30;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_SET   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd3;

  // Sample format codes.
  localparam logic [FMT_W-1:0] FMT_U8  = 2'd0;
  localparam logic [FMT_W-1:0] FMT_I16 = 2'd1;
  localparam logic [FMT_W-1:0] FMT_I32 = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_COUNT   = 2'd2;

  // Configuration reset values.
  localparam logic [FMT_W-1:0]   FMT_RESET   = FMT_I16;
  localparam logic [CHCNT_W-1:0] CHCNT_RESET = 4'd2;
  localparam logic [FRCNT_W-1:0] FRCNT_RESET = 13'd4096;

  // Amplitudes are 2^k - 1 (127, 0x7fff, 0x7fffffff), so a scale is a
  // shift and a subtraction.
  localparam int AMP_SHIFT_U8  = 7;
  localparam int AMP_SHIFT_I16 = 15;
  localparam int AMP_SHIFT_I32 = 31;

  // Level constants in Q1.30.
  localparam logic [LEVEL_W-1:0] Q_ONE  = 32'h4000_0000;
  localparam logic [PROD_W-1:0]  Q_HALF = PROD_W'(32'h2000_0000);

  // Format limits and neutral code.
  localparam int U8_MIDSCALE = 128;
  localparam int U8_MAX      = 255;
  localparam int I16_MAX     = 'h7fff;
  localparam int I32_MAX     = 'h7fffffff;

  typedef struct packed {
    logic [FUNC_W-1:0]         func;
    logic [FRAME_W-1:0]        frame_index;
    logic [CHAN_W-1:0]         channel;
    logic signed [LEVEL_W-1:0] level;
  } pmb_req_t;

  typedef struct packed {
    logic                     status;
    logic signed [WORD_W-1:0] sample_word;
  } pmb_rsp_t;

endpackage

[rtl/pcm_mix_buffer_unit.sv]
// Channel   Direction  Handshake               Payload
// cfg       in         cfg_we                  cfg_index, cfg_data
// in        in         in_valid / in_stall     in_data (pmb_req_t)
// out       out        out_valid / out_stall   out_data (pmb_rsp_t)
//
// Set, add and read go from acceptance to a loaded result through a memory
// read step that also forms the product, a rounding step, and a mix and
// write-back step; a new request is taken only once the block is idle again.
// Clear sweeps the store one word a cycle, then loads its response.
// After reset the store is swept to zero while in_stall stays high;
// configuration writes are taken throughout. A result waiting on out_stall
// does not block acceptance of the next request; that request holds in its
// last step until the output register frees.
`timescale 1ns / 1ps

module pcm_mix_buffer_unit
  import pmb_pkg::*;
#(
  parameter int MAX_FRAMES   = 4096,
  parameter int MAX_CHANNELS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pmb_req_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output pmb_rsp_t              out_data
);

  localparam int DEPTH = MAX_FRAMES * MAX_CHANNELS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CHW   = $clog2(MAX_CHANNELS + 1);
  localparam int FRW   = $clog2(MAX_FRAMES + 1);
  localparam int PW    = FRAME_W + CHW;

  typedef enum logic [2:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_READ,
    ST_SCALE,
    ST_MIX
  } state_t;

  state_t state;

  // Configuration registers.
  logic [FMT_W-1:0]   sample_format;
  logic [CHCNT_W-1:0] channel_count;
  logic [FRCNT_W-1:0] frame_count;

  // Request registers.
  logic [FUNC_W-1:0] func_q;
  logic [FMT_W-1:0]  fmt_q;
  logic [AW-1:0]     addr_q;
  logic              err_q;
  logic [LEVEL_W-1:0] mag_q;
  logic              neg_q;
  logic [PROD_W-1:0] prod_q;
  logic [RND_W-1:0]  rnd_q;
  logic [WORD_W-1:0] fill_q;
  logic [AW-1:0]     sweep_addr;
  logic              sweep_reply;

  // Store and its ports.
  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data;
  logic              rd_en;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [WORD_W-1:0] mem_wdata;

  // Request decode signals.
  logic              in_acc;
  logic [FMT_W-1:0]  fmt_eff;
  logic [CHW-1:0]    chans_lim;
  logic [FRW-1:0]    frames_lim;
  logic              in_range;
  logic [AW-1:0]     addr_calc;
  logic [LEVEL_W-1:0] lvl_u;
  logic [LEVEL_W-1:0] lvl_abs;
  logic [LEVEL_W-1:0] mag_calc;
  logic [WORD_W-1:0] neutral_word;

  // Scaling and mixing signals.
  logic [PROD_W-1:0] prod_calc;
  logic [PROD_W-1:0] rnd_sum;
  logic signed [DEC_W-1:0] dec_val;
  logic signed [SUM_W-1:0] base_ext;
  logic signed [SUM_W-1:0] r_ext;
  logic signed [SUM_W-1:0] sum_val;
  logic signed [SUM_W-1:0] hi_lim;
  logic signed [SUM_W-1:0] lo_lim;
  logic signed [SUM_W-1:0] mix_val;
  logic signed [SUM_W-1:0] res_val;
  logic [WORD_W-1:0] wr_word;
  logic              out_free;
  logic              sweep_last;
  pmb_rsp_t          rsp_next;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_format <= FMT_RESET;
      channel_count <= CHCNT_RESET;
      frame_count   <= FRCNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SAMPLE_FORMAT: sample_format <= cfg_data[FMT_W-1:0];
        CFG_CHANNEL_COUNT: channel_count <= cfg_data[CHCNT_W-1:0];
        CFG_FRAME_COUNT:   frame_count   <= cfg_data[FRCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective format, counts limited to the store geometry, and address.
  always_comb begin
    fmt_eff    = (sample_format == FMT_U8 || sample_format == FMT_I16) ?
                 sample_format : FMT_I32;
    chans_lim  = (32'(channel_count) > MAX_CHANNELS) ? CHW'(MAX_CHANNELS)
                                                      : CHW'(channel_count);
    frames_lim = (32'(frame_count) > MAX_FRAMES) ? FRW'(MAX_FRAMES)
                                                  : FRW'(frame_count);
    in_range   = (32'(in_data.frame_index) < 32'(frames_lim)) &&
                 (32'(in_data.channel) < 32'(chans_lim));
    // A frame below the limit keeps the address below the store depth.
    addr_calc  = AW'(PW'(in_data.frame_index) * PW'(chans_lim) + PW'(in_data.channel));
    neutral_word = (fmt_eff == FMT_U8) ? WORD_W'(U8_MIDSCALE) : '0;
  end

  // Level magnitude: a set clamps it to one, a read scales nothing.
  always_comb begin
    lvl_u   = in_data.level;
    lvl_abs = lvl_u[LEVEL_W-1] ? (~lvl_u + 32'd1) : lvl_u;
    case (in_data.func)
      FUNC_SET:  mag_calc = (lvl_abs > Q_ONE) ? Q_ONE : lvl_abs;
      FUNC_ADD:  mag_calc = lvl_abs;
      default:   mag_calc = '0;
    endcase
  end

  // Magnitude times (2^k - 1), then rounding half away from zero.
  always_comb begin
    case (fmt_q)
      FMT_U8:  prod_calc = (PROD_W'(mag_q) << AMP_SHIFT_U8) - PROD_W'(mag_q);
      FMT_I16: prod_calc = (PROD_W'(mag_q) << AMP_SHIFT_I16) - PROD_W'(mag_q);
      default: prod_calc = (PROD_W'(mag_q) << AMP_SHIFT_I32) - PROD_W'(mag_q);
    endcase
    rnd_sum = prod_q + Q_HALF;
  end

  // Decode the stored word, mix in the scaled level and saturate.
  always_comb begin
    case (fmt_q)
      FMT_U8: begin
        dec_val = $signed({{(DEC_W-8){1'b0}}, rd_data[7:0]});
        hi_lim  = SUM_W'(U8_MAX);
        lo_lim  = '0;
      end
      FMT_I16: begin
        dec_val = $signed({{(DEC_W-16){rd_data[15]}}, rd_data[15:0]});
        hi_lim  = SUM_W'(I16_MAX);
        lo_lim  = -SUM_W'(I16_MAX);
      end
      default: begin
        dec_val = $signed({rd_data[WORD_W-1], rd_data});
        hi_lim  = SUM_W'(I32_MAX);
        lo_lim  = -SUM_W'(I32_MAX);
      end
    endcase
    if (func_q == FUNC_SET) begin
      base_ext = (fmt_q == FMT_U8) ? SUM_W'(U8_MIDSCALE) : '0;
    end else begin
      base_ext = SUM_W'(dec_val);
    end
    r_ext   = $signed(SUM_W'(rnd_q));
    sum_val = neg_q ? (base_ext - r_ext) : (base_ext + r_ext);
    if (sum_val > hi_lim) begin
      mix_val = hi_lim;
    end else if (sum_val < lo_lim) begin
      mix_val = lo_lim;
    end else begin
      mix_val = sum_val;
    end
    res_val = (func_q == FUNC_READ) ? base_ext : mix_val;
    wr_word = (fmt_q == FMT_U8) ? WORD_W'(res_val[7:0]) : res_val[WORD_W-1:0];
    if (err_q) begin
      rsp_next.status      = 1'b1;
      rsp_next.sample_word = '0;
    end else if (func_q == FUNC_CLEAR) begin
      rsp_next.status      = 1'b0;
      rsp_next.sample_word = fill_q;
    end else begin
      rsp_next.status      = 1'b0;
      rsp_next.sample_word = res_val[WORD_W-1:0];
    end
  end

  assign in_stall   = (state != ST_IDLE);
  assign in_acc     = in_valid && (state == ST_IDLE);
  assign out_free   = !out_valid || !out_stall;
  assign sweep_last = (sweep_addr == AW'(DEPTH - 1));

  // Store port control: the sweep owns the write port while it runs.
  always_comb begin
    rd_en     = (state == ST_READ) && !err_q;
    mem_we    = (state == ST_SWEEP) ||
                ((state == ST_MIX) && out_free && !err_q &&
                 (func_q == FUNC_SET || func_q == FUNC_ADD));
    mem_waddr = (state == ST_SWEEP) ? sweep_addr : addr_q;
    mem_wdata = (state == ST_SWEEP) ? fill_q : wr_word;
  end

  // Sample store: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[addr_q];
    end
  end

  // Sequencer, request registers and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_SWEEP;
      sweep_addr  <= '0;
      sweep_reply <= 1'b0;
      fill_q      <= '0;
      out_valid   <= 1'b0;
    end else begin
      // The output register loads from the last step and empties when taken.
      if (state == ST_MIX && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_SWEEP: begin
          if (sweep_last) begin
            sweep_addr  <= '0;
            sweep_reply <= 1'b0;
            state       <= sweep_reply ? ST_MIX : ST_IDLE;
          end else begin
            sweep_addr <= sweep_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            func_q <= in_data.func;
            fmt_q  <= fmt_eff;
            addr_q <= addr_calc;
            err_q  <= !in_range && (in_data.func != FUNC_CLEAR);
            mag_q  <= mag_calc;
            neg_q  <= in_data.level[LEVEL_W-1];
            if (in_data.func == FUNC_CLEAR) begin
              fill_q      <= neutral_word;
              sweep_reply <= 1'b1;
              state       <= ST_SWEEP;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: begin
          prod_q <= prod_calc;
          state  <= ST_SCALE;
        end
        ST_SCALE: begin
          rnd_q <= rnd_sum[Q_FRAC +: RND_W];
          state <= ST_MIX;
        end
        ST_MIX: begin
          if (out_free) begin
            out_data <= rsp_next;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // A rejected request never touches the store.
  a_no_write_on_error: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == ST_MIX) |->
      (!err_q && (func_q == FUNC_SET || func_q == FUNC_ADD)))
    else $error("store written for a rejected or non-writing request");

  // An error response carries a zero sample word.
  a_error_word_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status) |-> (out_data.sample_word == '0))
    else $error("error response with non-zero sample word");

  // Leaving reset starts the clearing sweep from the first entry.
  a_reset_sweep: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> (state == ST_SWEEP && sweep_addr == '0 && !out_valid))
    else $error("reset did not start the store sweep");

  // The sweep steps through the store one entry a cycle.
  a_sweep_step: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SWEEP && $past(state == ST_SWEEP) && !$past(rst)) |->
      (sweep_addr == AW'($past(sweep_addr) + 1'b1)))
    else $error("sweep address skipped an entry");

endmodule

[tb/pcm_mix_buffer_unit_tb.sv]
`timescale 1ns / 1ps

module pcm_mix_buffer_unit_tb;
  import pmb_pkg::*;

  localparam int MAX_FRAMES   = 4096;
  localparam int MAX_CHANNELS = 8;
  localparam int STORE_DEPTH  = MAX_FRAMES * MAX_CHANNELS;

  // Format code 3 is not named in the package; the block treats it as i32.
  localparam logic [FMT_W-1:0]     FMT_ALIAS_I32 = 2'd3;
  // Register index 3 addresses nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED    = 2'd3;

  localparam longint LVL_UNITY = longint'(Q_ONE);
  localparam longint LVL_HALF  = LVL_UNITY >>> 1;

  localparam logic [LEVEL_W-1:0] LVL_MAX_POS = 32'h7fff_ffff;
  localparam logic [LEVEL_W-1:0] LVL_MAX_NEG = 32'h8000_0000;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic     in_valid  = 1'b0;
  logic     in_stall;
  pmb_req_t in_data   = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  pmb_rsp_t out_data;

  // Shadow copy of the block's configuration and sample store.
  logic [FMT_W-1:0]   cur_format   = FMT_RESET;
  logic [CHCNT_W-1:0] cur_channels = CHCNT_RESET;
  logic [FRCNT_W-1:0] cur_frames   = FRCNT_RESET;
  logic [WORD_W-1:0]  shadow_store [0:STORE_DEPTH-1];

  pmb_rsp_t awaited_results [$];
  int       mismatch_count = 0;
  int       send_idle_pct  = 0;
  int       stall_pct      = 0;
  int       clears_left    = 6;

  pcm_mix_buffer_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Sample arithmetic of the store.
  function automatic longint amplitude(input logic [FMT_W-1:0] fmt);
    if (fmt == FMT_U8) return 127;
    if (fmt == FMT_I16) return longint'(I16_MAX);
    return longint'(I32_MAX);
  endfunction

  function automatic longint neutral_code(input logic [FMT_W-1:0] fmt);
    return (fmt == FMT_U8) ? longint'(U8_MIDSCALE) : 0;
  endfunction

  // Level times amplitude over 2^30, rounded half away from zero.
  function automatic longint scaled_level(input longint lvl, input logic [FMT_W-1:0] fmt);
    longint mag;
    longint r;
    mag = (lvl < 0) ? -lvl : lvl;
    r = (mag * amplitude(fmt) + LVL_HALF) >>> Q_FRAC;
    return (lvl < 0) ? -r : r;
  endfunction

  function automatic longint decode_word(input logic [WORD_W-1:0] w,
                                         input logic [FMT_W-1:0] fmt);
    if (fmt == FMT_U8) return longint'({24'd0, w[7:0]});
    if (fmt == FMT_I16) return longint'($signed(w[15:0]));
    return longint'($signed(w));
  endfunction

  function automatic logic [WORD_W-1:0] store_code(input longint v,
                                                   input logic [FMT_W-1:0] fmt);
    if (fmt == FMT_U8) return {24'd0, v[7:0]};
    return v[31:0];
  endfunction

  // Applies one request to the shadow store and returns the response it earns.
  function automatic pmb_rsp_t mix_outcome(input pmb_req_t req);
    logic [FMT_W-1:0] fmt;
    int chans;
    int frames;
    int addr;
    longint lvl;
    longint v;
    longint lo;
    longint hi;
    logic [WORD_W-1:0] w;
    pmb_rsp_t rsp;
    fmt = (cur_format >= FMT_I32) ? FMT_I32 : cur_format;
    chans = (cur_channels > MAX_CHANNELS) ? MAX_CHANNELS : int'(cur_channels);
    frames = (cur_frames > MAX_FRAMES) ? MAX_FRAMES : int'(cur_frames);
    lvl = longint'($signed(req.level));
    rsp = '0;
    if (req.func == FUNC_CLEAR) begin
      w = store_code(neutral_code(fmt), fmt);
      foreach (shadow_store[i]) shadow_store[i] = w;
      rsp.sample_word = w;
      return rsp;
    end
    addr = int'(req.frame_index) * chans + int'(req.channel);
    if (int'(req.frame_index) >= frames || int'(req.channel) >= chans ||
        addr >= STORE_DEPTH) begin
      rsp.status = 1'b1;
      return rsp;
    end
    if (req.func == FUNC_SET) begin
      // A set clamps the level to [-1, 1] first.
      if (lvl > LVL_UNITY) lvl = LVL_UNITY;
      if (lvl < -LVL_UNITY) lvl = -LVL_UNITY;
      v = neutral_code(fmt) + scaled_level(lvl, fmt);
      shadow_store[addr] = store_code(v, fmt);
    end else if (req.func == FUNC_ADD) begin
      // An add takes the level as it is; only the sum saturates.
      if (fmt == FMT_U8) begin
        hi = longint'(U8_MAX);
        lo = 0;
      end else begin
        hi = amplitude(fmt);
        lo = -hi;
      end
      v = decode_word(shadow_store[addr], fmt) + scaled_level(lvl, fmt);
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      shadow_store[addr] = store_code(v, fmt);
    end
    v = decode_word(shadow_store[addr], fmt);
    rsp.sample_word = v[31:0];
    return rsp;
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Every accepted response is compared with the oldest prediction.
  always @(posedge clk) begin : check_response
    pmb_rsp_t want;
    if (!rst && out_valid && !out_stall) begin
      if (awaited_results.size() == 0) begin
        report_mismatch($sformatf("response %h with nothing awaited", out_data));
      end else begin
        want = awaited_results.pop_front();
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %b, expected %b",
                                    out_data.status, want.status));
        if (out_data.sample_word !== want.sample_word)
          report_mismatch($sformatf("sample_word %h, expected %h",
                                    out_data.sample_word, want.sample_word));
      end
    end
  end

  // Presents one request, idling first at the current rate, and predicts its
  // response once it is accepted.
  task automatic send_request(input logic [FUNC_W-1:0] func,
                              input logic [FRAME_W-1:0] frame,
                              input logic [CHAN_W-1:0] chan,
                              input logic [LEVEL_W-1:0] level);
    pmb_req_t req;
    req.func        = func;
    req.frame_index = frame;
    req.channel     = chan;
    req.level       = level;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    awaited_results.push_back(mix_outcome(req));
  endtask

  // Waits until every predicted response has been taken.
  task automatic await_drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // Writes all registers, the unused index included, with the enable held high.
  task automatic program_setup(input logic [CFG_DATA_W-1:0] fmt_data,
                               input logic [CFG_DATA_W-1:0] chan_data,
                               input logic [CFG_DATA_W-1:0] frame_data);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SAMPLE_FORMAT;
    cfg_data  <= fmt_data;
    @(posedge clk);
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_data  <= chan_data;
    @(posedge clk);
    cfg_index <= CFG_FRAME_COUNT;
    cfg_data  <= frame_data;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data  <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_format   = fmt_data[FMT_W-1:0];
    cur_channels = chan_data[CHCNT_W-1:0];
    cur_frames   = frame_data[FRCNT_W-1:0];
  endtask

  task automatic set_idling(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        stall_pct     = 0;
      end
      1: begin
        send_idle_pct = 82;
        stall_pct     = 0;
      end
      2: begin
        send_idle_pct = 0;
        stall_pct     = 82;
      end
      default: begin
        send_idle_pct = 14;
        stall_pct     = 14;
      end
    endcase
  endtask

  // Reset configuration: i16, two channels, full frame range, zeroed store.
  task automatic test_reset_defaults();
    send_request(FUNC_READ, 12'd0, 3'd0, '0);
    send_request(FUNC_READ, 12'd4095, 3'd1, '0);
    send_request(FUNC_READ, 12'd0, 3'd2, '0);
    await_drain();
  endtask

  // i32 limits, level clamping and rounding; the counts are over their maxima
  // and the format write carries junk above its two bits.
  task automatic test_i32_saturation();
    program_setup({11'h7fe, FMT_I32}, 13'd15, 13'h1fff);
    send_request(FUNC_SET, 12'd4095, 3'd7, LVL_MAX_POS);
    send_request(FUNC_ADD, 12'd4095, 3'd7, Q_ONE);
    send_request(FUNC_SET, 12'd0, 3'd0, LVL_MAX_NEG);
    send_request(FUNC_ADD, 12'd0, 3'd0, LVL_MAX_NEG);
    send_request(FUNC_SET, 12'd1, 3'd3, 32'd1);
    send_request(FUNC_ADD, 12'd1, 3'd3, 32'hffff_ffff);
    send_request(FUNC_READ, 12'd4095, 3'd7, '0);
    await_drain();
  endtask

  // u8 clear to the offset code, unclamped add levels and the range check on
  // a single-entry store.
  task automatic test_u8_clear_and_mix();
    program_setup(FMT_U8, 13'd1, 13'd1);
    send_request(FUNC_CLEAR, 12'hfff, 3'd7, 32'h1234_5678);
    send_request(FUNC_ADD, 12'd0, 3'd0, LVL_MAX_POS);
    send_request(FUNC_SET, 12'd0, 3'd0, -Q_ONE);
    send_request(FUNC_ADD, 12'd0, 3'd0, LVL_MAX_NEG);
    send_request(FUNC_READ, 12'd1, 3'd0, '0);
    send_request(FUNC_SET, 12'd0, 3'd1, Q_ONE);
    await_drain();
  endtask

  // A zero channel or frame count rejects every addressed request.
  task automatic test_empty_geometry();
    program_setup(FMT_I16, 13'd0, 13'd4096);
    send_request(FUNC_SET, 12'd0, 3'd0, Q_ONE);
    send_request(FUNC_READ, 12'd0, 3'd0, '0);
    await_drain();
    program_setup(FMT_I16, 13'd8, 13'd0);
    send_request(FUNC_ADD, 12'd0, 3'd0, Q_ONE);
    send_request(FUNC_READ, 12'd0, 3'd0, '0);
    await_drain();
  endtask

  // A word written under format code 3 is read back as i16 and then added to as u8.
  task automatic test_format_reinterpret();
    program_setup(FMT_ALIAS_I32, 13'd8, 13'd4096);
    send_request(FUNC_SET, 12'd2, 3'd5, 32'hf123_4567);
    await_drain();
    program_setup(FMT_I16, 13'd8, 13'd4096);
    send_request(FUNC_READ, 12'd2, 3'd5, '0);
    await_drain();
    program_setup(FMT_U8, 13'd8, 13'd4096);
    send_request(FUNC_ADD, 12'd2, 3'd5, 32'h0100_0000);
    await_drain();
  endtask

  // Random phases: mostly in-range traffic on a few hot frames so that adds
  // pile up and saturate, with some out-of-range noise and rare clears.
  task automatic test_random_mix();
    int fr_eff;
    int ch_eff;
    int pick;
    logic [FUNC_W-1:0]  func;
    logic [FRAME_W-1:0] frame;
    logic [CHAN_W-1:0]  chan;
    logic [LEVEL_W-1:0] lvl;
    logic [CFG_DATA_W-1:0] fmt_data;
    logic [CFG_DATA_W-1:0] chan_data;
    logic [CFG_DATA_W-1:0] frame_data;
    for (int phase = 0; phase < 12; phase++) begin
      case (phase)
        0: program_setup(FMT_U8, 13'd8, 13'd4096);
        1: program_setup(FMT_I16, 13'd1, 13'd1);
        2: program_setup(FMT_I32, 13'd8, 13'h1fff);
        3: program_setup(FMT_ALIAS_I32, 13'd15, 13'd3);
        default: begin
          fmt_data  = {11'($urandom), 2'($urandom_range(0, 3))};
          chan_data = ($urandom_range(0, 3) == 0) ? 13'($urandom) :
                      13'($urandom_range(1, 8));
          case ($urandom_range(0, 3))
            0: frame_data = 13'($urandom);
            1: frame_data = 13'($urandom_range(1, 8));
            2: frame_data = 13'd4096;
            default: frame_data = 13'($urandom_range(1, 64));
          endcase
          program_setup(fmt_data, chan_data, frame_data);
        end
      endcase
      set_idling(phase % 4);
      fr_eff = (cur_frames > MAX_FRAMES) ? MAX_FRAMES : int'(cur_frames);
      ch_eff = (cur_channels > MAX_CHANNELS) ? MAX_CHANNELS : int'(cur_channels);
      for (int n = 0; n < 85; n++) begin
        pick = $urandom_range(0, 99);
        if (clears_left > 0 && $urandom_range(0, 299) == 0) begin
          func = FUNC_CLEAR;
          clears_left--;
        end else if (pick < 40) begin
          func = FUNC_ADD;
        end else if (pick < 65) begin
          func = FUNC_SET;
        end else begin
          func = FUNC_READ;
        end
        if (fr_eff == 0 || ch_eff == 0 || $urandom_range(0, 99) < 15) begin
          frame = FRAME_W'($urandom);
          chan  = CHAN_W'($urandom);
        end else begin
          if (fr_eff > 4 && $urandom_range(0, 1) == 1) frame = FRAME_W'($urandom_range(0, 3));
          else frame = FRAME_W'($urandom_range(0, fr_eff - 1));
          chan = CHAN_W'($urandom_range(0, ch_eff - 1));
        end
        case ($urandom_range(0, 5))
          0: lvl = $urandom;
          1: lvl = Q_ONE;
          2: lvl = -Q_ONE;
          3: lvl = $signed($urandom) >>> $urandom_range(1, 30);
          4: begin
            // Just either side of full scale, to hit the clamp edges.
            lvl = Q_ONE + $urandom_range(0, 64) - 32;
            if ($urandom_range(0, 1) == 1) lvl = -lvl;
          end
          default: lvl = ($urandom_range(0, 1) == 1) ? LVL_MAX_POS : LVL_MAX_NEG;
        endcase
        send_request(func, frame, chan, lvl);
      end
      await_drain();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    set_idling(0);
    test_reset_defaults();
    test_i32_saturation();
    test_u8_clear_and_mix();
    test_empty_geometry();
    test_format_reinterpret();
    test_random_mix();
    set_idling(0);
    // Let any stray response surface before the verdict.
    repeat (16) @(posedge clk);
    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("pcm_mix_buffer_unit_tb: PASS");
    end else begin
      $display("pcm_mix_buffer_unit_tb: FAIL");
    end
    $finish;
  end

  // Backstop for a hung handshake.
  initial begin
    #20_000_000;
    $display("pcm_mix_buffer_unit_tb: FAIL");
    $finish;
  end

endmodule
